// File: hdl/i2cm_pkg.sv
// Shared types and constants of the I2C master byte engine.
package i2cm_pkg;

  // Command codes carried in req_type
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned HD_W       = 16;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned BYTE_BITS  = 8;

  localparam logic [HD_W-1:0] HALF_DELAY_RESET = HD_W'(10);

  // Phases per command sequence
  localparam logic [STEP_W-1:0] START_PHASES = STEP_W'(3);
  localparam logic [STEP_W-1:0] STOP_PHASES  = STEP_W'(1);
  localparam logic [STEP_W-1:0] WRITE_PHASES = STEP_W'(BYTE_BITS * 3);
  localparam logic [STEP_W-1:0] ACK_PHASES   = STEP_W'(3);
  localparam logic [STEP_W-1:0] READ_PHASES  = STEP_W'(BYTE_BITS * 2 + 3);

  // Read sequence landmarks
  localparam logic [STEP_W-1:0] READ_ACK_PHASE = STEP_W'(BYTE_BITS * 2);
  localparam logic [STEP_W-1:0] READ_SCL_PHASE = STEP_W'(BYTE_BITS * 2 + 1);

endpackage

// File: hdl/i2cm_if.sv
// Channel interfaces of the I2C master byte engine: tick items, results, config writes.
interface i2cm_item_if;
  logic       valid;
  logic       ready;
  logic       sda_in;
  logic       cmd_valid;
  logic [2:0] req_type;
  logic [7:0] tx_byte;
  logic       send_ack;

  modport source (output valid, sda_in, cmd_valid, req_type, tx_byte, send_ack,
                  input ready);
  modport sink   (input valid, sda_in, cmd_valid, req_type, tx_byte, send_ack,
                  output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_missing,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_missing,
                   output ready);
endinterface

interface i2cm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [i2cm_pkg::HD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/i2c_master_byte_engine.sv
// I2C master byte engine: one bus tick per item, pin levels and status per result.
// Each accepted item is one bus tick and yields exactly one result; an item is
// taken every clock cycle as long as the result register is
// empty or being drained, so the result register is the only thing that sets the
// rate. A command (start, stop, write byte, ack check, read byte with ACK/NACK)
// is taken only on a tick that finds the engine idle; every pin change is then
// held for half_delay ticks (0 counts as 1), and the tick after the last phase
// applies any final pin change (stop, read) and pulses done_res. The half_delay register is
// written through the config channel, which is always ready.
module i2c_master_byte_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cm_item_if.sink    item_i,
  i2cm_res_if.source   res_o,
  i2cm_cfg_if.sink     cfg_i
);

  logic [i2cm_pkg::HD_W-1:0]    half_delay_q;
  logic [i2cm_pkg::STEP_W-1:0]  step_q, step_d;
  i2cm_pkg::cmd_e               kind_q, kind_d;
  logic [1:0]                   sub_q, sub_d;
  logic [7:0]                   shift_q, shift_d;
  logic [i2cm_pkg::DELAY_W-1:0] delay_q, delay_d;
  logic                         aar_q, aar_d;
  logic                         scl_q, scl_d;
  logic                         sda_q, sda_d;
  logic [7:0]                   cap_q, cap_d;
  logic                         ack_q, ack_d;
  logic                         done_d;
  logic                         out_valid_q;
  logic                         item_acc;

  // Item flow: take a tick whenever the result register can be refilled
  assign item_i.ready = !out_valid_q || res_o.ready;
  assign item_acc     = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign res_o.valid  = out_valid_q;

  // Phase count of the running sequence
  function automatic logic [i2cm_pkg::STEP_W-1:0] phase_cnt(i2cm_pkg::cmd_e k);
    logic [i2cm_pkg::STEP_W-1:0] n;
    case (k)
      i2cm_pkg::CMD_START: n = i2cm_pkg::START_PHASES;
      i2cm_pkg::CMD_STOP:  n = i2cm_pkg::STOP_PHASES;
      i2cm_pkg::CMD_WRITE: n = i2cm_pkg::WRITE_PHASES;
      i2cm_pkg::CMD_ACK:   n = i2cm_pkg::ACK_PHASES;
      default:             n = i2cm_pkg::READ_PHASES;
    endcase
    return n;
  endfunction

  // Next state for one tick
  always_comb begin
    logic                         enter;
    logic [i2cm_pkg::STEP_W-1:0]  p;
    logic [1:0]                   r;
    logic [i2cm_pkg::DELAY_W-1:0] hd;
    step_d  = step_q;
    kind_d  = kind_q;
    sub_d   = sub_q;
    shift_d = shift_q;
    delay_d = delay_q;
    aar_d   = aar_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    cap_d   = cap_q;
    ack_d   = ack_q;
    done_d  = 1'b0;
    enter   = 1'b0;
    p       = step_q;
    r       = 2'd0;
    hd      = half_delay_q[i2cm_pkg::DELAY_W-1:0];
    if (hd == '0) begin
      hd = i2cm_pkg::DELAY_W'(1);
    end

    if (step_q == '0) begin
      // Idle: accept a known command
      if (item_i.cmd_valid && (item_i.req_type <= 3'(i2cm_pkg::CMD_READ))) begin
        kind_d  = i2cm_pkg::cmd_e'(item_i.req_type);
        shift_d = (kind_d == i2cm_pkg::CMD_WRITE) ? item_i.tx_byte : 8'h00;
        aar_d   = item_i.send_ack;
        sub_d   = 2'd0;
        p       = '0;
        enter   = 1'b1;
      end
    end else if (delay_q > i2cm_pkg::DELAY_W'(1)) begin
      delay_d = delay_q - i2cm_pkg::DELAY_W'(1);
    end else if (step_q < phase_cnt(kind_q)) begin
      enter = 1'b1;
    end else begin
      // Completion: final pin change
      if (kind_q == i2cm_pkg::CMD_STOP) begin
        sda_d = 1'b1;
      end
      if (kind_q == i2cm_pkg::CMD_READ) begin
        sda_d = 1'b1;
        cap_d = shift_q;
      end
      step_d  = '0;
      delay_d = '0;
      done_d  = 1'b1;
    end

    if (enter) begin
      r = sub_d;
      case (kind_d)
        i2cm_pkg::CMD_START: begin
          if (p == i2cm_pkg::STEP_W'(0)) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else if (p == i2cm_pkg::STEP_W'(1)) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        i2cm_pkg::CMD_STOP: begin
          sda_d = 1'b0;
          scl_d = 1'b1;
        end
        i2cm_pkg::CMD_WRITE: begin
          if (r == 2'd0) begin
            scl_d   = 1'b0;
            sda_d   = shift_d[7];
            shift_d = {shift_d[6:0], 1'b0};
          end else if (r == 2'd1) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        i2cm_pkg::CMD_ACK: begin
          if (p == i2cm_pkg::STEP_W'(0)) begin
            sda_d = 1'b1;
          end else if (p == i2cm_pkg::STEP_W'(1)) begin
            scl_d = 1'b1;
          end else begin
            ack_d = item_i.sda_in;
            scl_d = 1'b0;
          end
        end
        default: begin
          // Read byte, then ACK or NACK
          if (p < i2cm_pkg::READ_ACK_PHASE) begin
            if (!p[0]) begin
              scl_d = 1'b0;
            end else begin
              scl_d   = 1'b1;
              shift_d = {shift_d[6:0], item_i.sda_in};
            end
          end else if (p == i2cm_pkg::READ_ACK_PHASE) begin
            sda_d = !aar_d;
          end else if (p == i2cm_pkg::READ_SCL_PHASE) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
      endcase
      // Track the phase within a write bit
      sub_d   = (r == 2'd2) ? 2'd0 : r + 2'd1;
      step_d  = p + i2cm_pkg::STEP_W'(1);
      delay_d = hd;
    end
  end

  // Hold engine state, config and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_delay_q <= i2cm_pkg::HALF_DELAY_RESET;
      step_q       <= '0;
      kind_q       <= i2cm_pkg::CMD_START;
      sub_q        <= 2'd0;
      shift_q      <= 8'h00;
      delay_q      <= '0;
      aar_q        <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      cap_q        <= 8'h00;
      ack_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        half_delay_q <= cfg_i.data;
      end
      if (item_acc) begin
        step_q  <= step_d;
        kind_q  <= kind_d;
        sub_q   <= sub_d;
        shift_q <= shift_d;
        delay_q <= delay_d;
        aar_q   <= aar_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        cap_q   <= cap_d;
        ack_q   <= ack_d;
      end
      if (item_acc) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load result payload for each accepted tick
  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      res_o.scl_out     <= scl_d;
      res_o.sda_out     <= sda_d;
      res_o.busy_res    <= (step_d != '0);
      res_o.done_res    <= done_d;
      res_o.rx_byte     <= cap_d;
      res_o.ack_missing <= ack_d;
    end
  end

endmodule

// File: hdl/i2cm_checker.sv
// Port-level assertions for the I2C master byte engine, bound to i2c_master_byte_engine.
module i2cm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       scl_i,
  input logic       sda_i,
  input logic       busy_i,
  input logic       done_i,
  input logic [7:0] rx_i,
  input logic       ack_i
);

  // A stalled result holds its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i &&
      $stable({scl_i, sda_i, busy_i, done_i, rx_i, ack_i}))
    else $error("stalled result changed");

  // Completion tick reports the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && done_i |-> !busy_i)
    else $error("done pulse with busy set");

  // Ticks are taken whenever the result register can drain
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!res_valid_i || res_ready_i))
    else $error("input ready does not follow result register");

  // Every accepted tick yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> res_valid_i)
    else $error("accepted tick without result");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .scl_i       (res_o.scl_out),
  .sda_i       (res_o.sda_out),
  .busy_i      (res_o.busy_res),
  .done_i      (res_o.done_res),
  .rx_i        (res_o.rx_byte),
  .ack_i       (res_o.ack_missing)
);
